[src/mdfts_pkg.sv]
// Shared constants, codes and widths of the multi-domain FIFO task scheduler.
`timescale 1ns / 1ps

package mdfts_pkg;

    // Sizing
    localparam int QUEUE_DEPTH  = 16;
    localparam int DOMAIN_SLOTS = 16;

    localparam int QIDX_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int DIDX_W  = (DOMAIN_SLOTS > 1) ? $clog2(DOMAIN_SLOTS) : 1;
    localparam int DCNT_W  = $clog2(DOMAIN_SLOTS + 1);
    localparam int QSTORE_DEPTH = DOMAIN_SLOTS * QUEUE_DEPTH;
    localparam int QADDR_W = (QSTORE_DEPTH > 1) ? $clog2(QSTORE_DEPTH) : 1;

    // Field widths
    localparam int OP_W     = 3;
    localparam int HANDLE_W = 32;
    localparam int DOMID_W  = 8;
    localparam int STATUS_W = 2;

    typedef logic [OP_W-1:0]     t_op;
    typedef logic [HANDLE_W-1:0] t_handle;
    typedef logic [DOMID_W-1:0]  t_domid;
    typedef logic [STATUS_W-1:0] t_status;
    typedef logic [QIDX_W-1:0]   t_qidx;
    typedef logic [DIDX_W-1:0]   t_didx;
    typedef logic [DCNT_W-1:0]   t_dcnt;
    typedef logic [QADDR_W-1:0]  t_qaddr;

    // Operation codes
    localparam t_op OP_CLEAR_ALL = 3'd0;
    localparam t_op OP_SELECT    = 3'd1;
    localparam t_op OP_RESET_CTX = 3'd2;
    localparam t_op OP_ENQUEUE   = 3'd3;
    localparam t_op OP_ELECT     = 3'd4;
    localparam t_op OP_GET_CUR   = 3'd5;
    localparam t_op OP_WIN_LEAVE = 3'd6;

    // Status codes
    localparam t_status STS_OK    = 2'd0;
    localparam t_status STS_NODOM = 2'd1;
    localparam t_status STS_FULL  = 2'd2;

endpackage

[src/multi_domain_fifo_task_scheduler.sv]
// Top level of the multi-domain FIFO ready-task scheduler.
`timescale 1ns / 1ps

// Ready-task FIFO scheduler with one ring queue of QUEUE_DEPTH handles and one
// current-task register per domain, for up to DOMAIN_SLOTS domains. Each
// accepted item gives exactly one result (status and handle). When an item is
// accepted, the queue store and current-task memory are read at the selected
// domain's head and context; the result is formed from the registered read
// data and written back once the output register is free. The result sits in
// an output register, so a stalled result only delays the write-back of the
// item behind it. The user must write the idle handle through the configuration
// port only while no item is in flight; the block does not enforce this.
module multi_domain_fifo_task_scheduler (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // Configuration: idle handle
    input  logic                     i_cfg_we,
    input  logic [31:0]              i_cfg_wdata,
    // Input items
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  mdfts_pkg::t_op           i_op,
    input  mdfts_pkg::t_handle       i_task_handle,
    input  mdfts_pkg::t_domid        i_domain,
    input  logic                     i_task_ready,
    // Result items
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output mdfts_pkg::t_status       o_status,
    output mdfts_pkg::t_handle       o_out_handle
);
    import mdfts_pkg::*;

    localparam logic STATE_IDLE = 1'b0;
    localparam logic STATE_EXEC = 1'b1;

    // Control state
    logic    r_state, n_state;
    t_handle r_idle, n_idle;
    logic    r_dom_valid [DOMAIN_SLOTS];
    logic    n_dom_valid [DOMAIN_SLOTS];
    t_dcnt   r_dom_count, n_dom_count;
    t_didx   r_sel, n_sel;
    logic    r_sel_valid, n_sel_valid;
    t_qidx   r_head [DOMAIN_SLOTS];
    t_qidx   n_head [DOMAIN_SLOTS];
    t_qidx   r_tail [DOMAIN_SLOTS];
    t_qidx   n_tail [DOMAIN_SLOTS];
    logic    r_empty [DOMAIN_SLOTS];
    logic    n_empty [DOMAIN_SLOTS];
    logic    r_out_valid, n_out_valid;

    // Payload state
    t_domid  r_dom_id [DOMAIN_SLOTS];
    t_domid  n_dom_id [DOMAIN_SLOTS];
    t_op     r_op;
    t_handle r_handle;
    t_domid  r_domain;
    logic    r_ready;
    t_status r_status, n_status;
    t_handle r_out_handle, n_out_handle;

    // Memory ports
    logic    q_we;
    t_qaddr  q_waddr, q_raddr;
    t_handle q_wdata, q_rdata;
    logic    c_we;
    t_didx   c_waddr;
    t_handle c_wdata, c_rdata;

    logic    accept, commit;

    // Ring index increment with wrap at the queue depth
    function automatic t_qidx qinc(input t_qidx idx);
        qinc = (idx == t_qidx'(QUEUE_DEPTH - 1)) ? '0 : idx + t_qidx'(1);
    endfunction

    function automatic t_qaddr qaddr(input t_didx d, input t_qidx idx);
        qaddr = t_qaddr'(d) * t_qaddr'(QUEUE_DEPTH) + t_qaddr'(idx);
    endfunction

    assign accept      = i_in_valid && o_in_ready;
    assign commit      = (r_state == STATE_EXEC) && (!r_out_valid || i_out_ready);
    assign o_in_ready  = (r_state == STATE_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_out_handle = r_out_handle;

    // Reads follow the registered selection, which holds until commit
    assign q_raddr = qaddr(r_sel, r_head[r_sel]);

    mdfts_ram #(.WIDTH(HANDLE_W), .DEPTH(QSTORE_DEPTH)) u_queue_ram (
        .i_clk   (i_clk),
        .i_we    (q_we),
        .i_waddr (q_waddr),
        .i_wdata (q_wdata),
        .i_raddr (q_raddr),
        .o_rdata (q_rdata)
    );

    mdfts_ram #(.WIDTH(HANDLE_W), .DEPTH(DOMAIN_SLOTS)) u_current_ram (
        .i_clk   (i_clk),
        .i_we    (c_we),
        .i_waddr (c_waddr),
        .i_wdata (c_wdata),
        .i_raddr (r_sel),
        .o_rdata (c_rdata)
    );

    // Domain lookup: parallel id compare, lowest matching slot wins
    logic  lk_found;
    t_didx lk_idx;
    always_comb begin
        lk_found = 1'b0;
        lk_idx   = '0;
        for (int i = 0; i < DOMAIN_SLOTS; i++) begin
            if (!lk_found && r_dom_valid[i] && (r_dom_id[i] == r_domain)) begin
                lk_found = 1'b1;
                lk_idx   = t_didx'(i);
            end
        end
    end

    // Operation decode and read-modify-write of the selected context
    logic    do_push;
    t_handle push_data;
    logic    sel_full;
    t_didx   new_slot;
    t_qidx   head_next;

    assign sel_full  = (r_tail[r_sel] == r_head[r_sel]) && !r_empty[r_sel];
    assign new_slot  = r_dom_count[DIDX_W-1:0];
    assign head_next = qinc(r_head[r_sel]);

    always_comb begin
        n_state      = r_state;
        n_idle       = r_idle;
        n_dom_valid  = r_dom_valid;
        n_dom_count  = r_dom_count;
        n_sel        = r_sel;
        n_sel_valid  = r_sel_valid;
        n_head       = r_head;
        n_tail       = r_tail;
        n_empty      = r_empty;
        n_dom_id     = r_dom_id;
        n_status     = r_status;
        n_out_handle = r_out_handle;
        n_out_valid  = r_out_valid && !i_out_ready;
        q_we         = 1'b0;
        q_waddr      = qaddr(r_sel, r_tail[r_sel]);
        q_wdata      = '0;
        c_we         = 1'b0;
        c_waddr      = r_sel;
        c_wdata      = r_idle;
        do_push      = 1'b0;
        push_data    = r_handle;

        if (i_cfg_we) begin
            n_idle = i_cfg_wdata;
        end

        if (accept) begin
            n_state = STATE_EXEC;
        end

        if (commit) begin
            n_state      = STATE_IDLE;
            n_out_valid  = 1'b1;
            n_status     = STS_OK;
            n_out_handle = '0;
            unique case (r_op)
                OP_CLEAR_ALL: begin
                    for (int i = 0; i < DOMAIN_SLOTS; i++) begin
                        n_dom_valid[i] = 1'b0;
                    end
                    n_dom_count = '0;
                    n_sel       = '0;
                    n_sel_valid = 1'b0;
                end
                OP_SELECT: begin
                    if (lk_found) begin
                        n_sel       = lk_idx;
                        n_sel_valid = 1'b1;
                    end else if (r_dom_count >= t_dcnt'(DOMAIN_SLOTS)) begin
                        n_status = STS_FULL;
                    end else begin
                        // Allocate the next free slot with an empty context
                        n_dom_id[new_slot]    = r_domain;
                        n_dom_valid[new_slot] = 1'b1;
                        n_head[new_slot]      = '0;
                        n_tail[new_slot]      = '0;
                        n_empty[new_slot]     = 1'b1;
                        c_we        = 1'b1;
                        c_waddr     = new_slot;
                        c_wdata     = r_idle;
                        n_sel       = new_slot;
                        n_sel_valid = 1'b1;
                        n_dom_count = r_dom_count + t_dcnt'(1);
                    end
                end
                OP_RESET_CTX: begin
                    if (!r_sel_valid) begin
                        n_status = STS_NODOM;
                    end else begin
                        n_head[r_sel]  = '0;
                        n_tail[r_sel]  = '0;
                        n_empty[r_sel] = 1'b1;
                        c_we    = 1'b1;
                        c_wdata = r_idle;
                    end
                end
                OP_ENQUEUE: begin
                    if (!r_sel_valid) begin
                        n_status = STS_NODOM;
                    end else if (sel_full) begin
                        n_status = STS_FULL;
                    end else begin
                        do_push   = 1'b1;
                        push_data = r_handle;
                    end
                end
                OP_ELECT: begin
                    n_out_handle = r_idle;
                    if (!r_sel_valid) begin
                        n_status = STS_NODOM;
                    end else if (!r_empty[r_sel]) begin
                        // Pop the head and make it current
                        n_out_handle  = q_rdata;
                        n_head[r_sel] = head_next;
                        if (head_next == r_tail[r_sel]) begin
                            n_empty[r_sel] = 1'b1;
                        end
                        c_we    = 1'b1;
                        c_wdata = q_rdata;
                    end
                end
                OP_GET_CUR: begin
                    n_out_handle = r_sel_valid ? c_rdata : r_idle;
                end
                OP_WIN_LEAVE: begin
                    // Requeue the running task; dropped silently when full
                    if (r_sel_valid && (c_rdata != r_idle) && r_ready && !sel_full) begin
                        do_push   = 1'b1;
                        push_data = c_rdata;
                    end
                end
                default: begin
                end
            endcase

            if (do_push) begin
                q_we           = 1'b1;
                q_wdata        = push_data;
                n_tail[r_sel]  = qinc(r_tail[r_sel]);
                n_empty[r_sel] = 1'b0;
            end
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= STATE_IDLE;
            r_idle      <= '0;
            r_dom_count <= '0;
            r_sel       <= '0;
            r_sel_valid <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < DOMAIN_SLOTS; i++) begin
                r_dom_valid[i] <= 1'b0;
                r_head[i]      <= '0;
                r_tail[i]      <= '0;
                r_empty[i]     <= 1'b1;
            end
        end else begin
            r_state     <= n_state;
            r_idle      <= n_idle;
            r_dom_count <= n_dom_count;
            r_sel       <= n_sel;
            r_sel_valid <= n_sel_valid;
            r_out_valid <= n_out_valid;
            r_dom_valid <= n_dom_valid;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_empty     <= n_empty;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op     <= i_op;
            r_handle <= i_task_handle;
            r_domain <= i_domain;
            r_ready  <= i_task_ready;
        end
        r_dom_id     <= n_dom_id;
        r_status     <= n_status;
        r_out_handle <= n_out_handle;
    end

endmodule

[src/mdfts_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module mdfts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read, old data on a same-edge collision
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
